[sv/cncfp_pkg.sv]
// Package for the CNC command frame parser: character codes, capture types,
// the window length and the result record.
// No dependencies.
package cncfp_pkg;

	// Longest numeric value window after '=', limited to one through six
	localparam int MAX_FIELD_CHARS = 3;
	localparam int WINDOW = (MAX_FIELD_CHARS < 1) ? 1 :
		((MAX_FIELD_CHARS > 6) ? 6 : MAX_FIELD_CHARS);
	localparam int WIN_W = $clog2(WINDOW + 1);

	// Value width and saturation limits
	localparam int VAL_W = 11;
	localparam int MUL_W = VAL_W + 4;
	localparam logic signed [MUL_W-1:0] VAL_MIN = -(MUL_W'(1) <<< (VAL_W - 1));
	localparam logic signed [MUL_W-1:0] VAL_MAX = (MUL_W'(1) <<< (VAL_W - 1)) - 1;

	// Character codes
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_S      = 8'h53;
	localparam logic [7:0] CH_X      = 8'h58;
	localparam logic [7:0] CH_Y      = 8'h59;
	localparam logic [7:0] CH_Z      = 8'h5A;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_3      = 8'h33;
	localparam logic [7:0] CH_4      = 8'h34;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;

	// Found flag bits
	localparam int FLAG_M3 = 4;
	localparam int FLAG_M4 = 5;

	// Value being captured
	typedef enum logic [2:0] {
		TGT_NONE = 3'd0,
		TGT_S    = 3'd1,
		TGT_X    = 3'd2,
		TGT_Y    = 3'd3,
		TGT_Z    = 3'd4
	} target_t;

	// Capture phase
	typedef enum logic [1:0] {
		PH_BLANK = 2'd0,
		PH_SIGN  = 2'd1,
		PH_DIGIT = 2'd2
	} phase_t;

	// One frame result, last field in the lowest bits
	typedef struct packed {
		logic                    counterclockwise_found;
		logic                    clockwise_found;
		logic signed [VAL_W-1:0] zpos_value;
		logic                    zpos_found;
		logic signed [VAL_W-1:0] ypos_value;
		logic                    ypos_found;
		logic signed [VAL_W-1:0] xpos_value;
		logic                    xpos_found;
		logic signed [VAL_W-1:0] speed_value;
		logic                    speed_found;
	} result_t;

	localparam int RES_W = $bits(result_t);
	localparam int OUT_W = ((RES_W + 7) / 8) * 8;

endpackage

[sv/cncfp_core.sv]
// Frame parser state and per-byte update: marker detection, value capture
// and the frame result on '#'.
// Depends on cncfp_pkg.
module cncfp_core
	import cncfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] rx_byte,
	output logic       res_valid,
	output result_t    res
);

	logic                    in_frame_q, in_frame_n;
	logic [7:0]              prev_q, prev_n;
	target_t                 tgt_q, tgt_n;
	logic [WIN_W-1:0]        win_q, win_n, win_dec;
	phase_t                  phase_q, phase_n;
	logic                    neg_q, neg_n;
	logic signed [VAL_W-1:0] vals_q [4];
	logic signed [VAL_W-1:0] vals_n [4];
	logic [5:0]              flags_q, flags_n;

	logic                    is_digit, is_blank, keep;
	logic [1:0]              cap_slot, start_slot;
	logic [3:0]              digit;
	logic signed [MUL_W-1:0] old_ext, mul10, acc;
	logic signed [VAL_W-1:0] sat_val;
	logic                    start_en;
	target_t                 start_tgt;

	// Classify the byte
	assign is_digit = (rx_byte >= CH_0) && (rx_byte <= CH_9);
	assign is_blank = (rx_byte == CH_SPACE) || ((rx_byte >= CH_TAB) && (rx_byte <= CH_CR));
	assign digit    = 4'(rx_byte - CH_0);
	assign cap_slot = 2'(tgt_q - 3'd1);
	assign win_dec  = (win_q != '0) ? win_q - 1'b1 : '0;

	// Accumulate one decimal digit with saturation
	assign old_ext = MUL_W'(vals_q[cap_slot]);
	assign mul10   = (old_ext <<< 3) + (old_ext <<< 1);
	assign acc     = neg_q ? mul10 - MUL_W'(digit) : mul10 + MUL_W'(digit);
	assign sat_val = (acc < VAL_MIN) ? VAL_W'(VAL_MIN) :
		((acc > VAL_MAX) ? VAL_W'(VAL_MAX) : VAL_W'(acc));

	// Value marker selected by the previous byte
	always_comb begin
		start_tgt = TGT_NONE;
		case (prev_q)
			CH_S: start_tgt = TGT_S;
			CH_X: start_tgt = TGT_X;
			CH_Y: start_tgt = TGT_Y;
			CH_Z: start_tgt = TGT_Z;
			default: start_tgt = TGT_NONE;
		endcase
	end
	assign start_slot = 2'(start_tgt - 3'd1);
	assign start_en   = (rx_byte == CH_EQ) && (start_tgt != TGT_NONE) && !flags_q[start_slot];

	// Next state for one accepted byte
	always_comb begin
		in_frame_n = in_frame_q;
		prev_n     = prev_q;
		tgt_n      = tgt_q;
		win_n      = win_q;
		phase_n    = phase_q;
		neg_n      = neg_q;
		vals_n     = vals_q;
		flags_n    = flags_q;
		res_valid  = 1'b0;
		keep       = 1'b0;
		if (step) begin
			if (!in_frame_q) begin
				// Drop bytes until a frame opens
				if (rx_byte == CH_DOLLAR) begin
					in_frame_n = 1'b1;
					prev_n     = rx_byte;
					tgt_n      = TGT_NONE;
					win_n      = '0;
					phase_n    = PH_BLANK;
					neg_n      = 1'b0;
					vals_n     = '{default: '0};
					flags_n    = '0;
				end
			end else if (rx_byte == CH_HASH) begin
				// Close the frame and clear
				res_valid  = 1'b1;
				in_frame_n = 1'b0;
				prev_n     = '0;
				tgt_n      = TGT_NONE;
				win_n      = '0;
				phase_n    = PH_BLANK;
				neg_n      = 1'b0;
				vals_n     = '{default: '0};
				flags_n    = '0;
			end else begin
				// Feed a running value capture
				if (tgt_q != TGT_NONE) begin
					if (phase_q == PH_BLANK) begin
						if (is_blank) begin
							keep = 1'b1;
						end else if ((rx_byte == CH_PLUS) || (rx_byte == CH_MINUS)) begin
							neg_n   = (rx_byte == CH_MINUS);
							phase_n = PH_SIGN;
							keep    = 1'b1;
						end else if (is_digit) begin
							phase_n          = PH_DIGIT;
							vals_n[cap_slot] = sat_val;
							keep             = 1'b1;
						end
					end else if (is_digit) begin
						phase_n          = PH_DIGIT;
						vals_n[cap_slot] = sat_val;
						keep             = 1'b1;
					end
					win_n = win_dec;
					if (!keep || (win_dec == '0)) begin
						tgt_n   = TGT_NONE;
						win_n   = '0;
						phase_n = PH_BLANK;
						neg_n   = 1'b0;
					end
				end
				// Start a new value or note a spindle marker
				if (start_en) begin
					flags_n[start_slot] = 1'b1;
					tgt_n               = start_tgt;
					win_n               = WIN_W'(WINDOW);
					phase_n             = PH_BLANK;
					neg_n               = 1'b0;
					vals_n[start_slot]  = '0;
				end else if ((rx_byte != CH_EQ) && (prev_q == CH_M)) begin
					if (rx_byte == CH_3) begin
						flags_n[FLAG_M3] = 1'b1;
					end else if (rx_byte == CH_4) begin
						flags_n[FLAG_M4] = 1'b1;
					end
				end
				prev_n = rx_byte;
			end
		end
	end

	// Hold the frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			prev_q     <= '0;
			tgt_q      <= TGT_NONE;
			win_q      <= '0;
			phase_q    <= PH_BLANK;
			neg_q      <= 1'b0;
			vals_q     <= '{default: '0};
			flags_q    <= '0;
		end else begin
			in_frame_q <= in_frame_n;
			prev_q     <= prev_n;
			tgt_q      <= tgt_n;
			win_q      <= win_n;
			phase_q    <= phase_n;
			neg_q      <= neg_n;
			vals_q     <= vals_n;
			flags_q    <= flags_n;
		end
	end

	// Result from the state before the closing byte
	always_comb begin
		res.speed_found            = flags_q[0];
		res.speed_value            = vals_q[0];
		res.xpos_found             = flags_q[1];
		res.xpos_value             = vals_q[1];
		res.ypos_found             = flags_q[2];
		res.ypos_value             = vals_q[2];
		res.zpos_found             = flags_q[3];
		res.zpos_value             = vals_q[3];
		res.clockwise_found        = flags_q[FLAG_M3];
		res.counterclockwise_found = flags_q[FLAG_M4];
	end

endmodule

[sv/cnc_command_frame_parser_unit.sv]
// CNC command frame parser, top level: input register, parser core and
// result register on stream handshakes.
// Depends on cncfp_pkg and cncfp_core.
// The '#' byte passes the input register, then the result register, to m_tvalid.
// Throughput: one byte per cycle while no result waits for m_tready; while one
// waits, the input register still takes a new byte if it is empty.
// Reset: arst_n clears the frame state and both valid flags at once; the
// parser then waits for '$'.
module cnc_command_frame_parser_unit
	import cncfp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,   // rx_byte
	output logic             m_tvalid,
	input  logic             m_tready,
	// speed_found, speed_value, xpos_found, xpos_value, ypos_found, ypos_value,
	// zpos_found, zpos_value, clockwise_found, counterclockwise_found, zero fill
	output logic [OUT_W-1:0] m_tdata
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       step;
	logic       res_valid;
	result_t    res;
	logic       out_valid_q;
	result_t    out_q;

	// Move forward unless a result is stuck at the output
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign step     = valid_s1 && advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	cncfp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.rx_byte   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'(out_q);

endmodule
